### sv/tcc_pkg.sv
package tcc_pkg;

    // Internal cursor widths: the column must hold COLUMNS itself before the
    // wrap is taken, and the row must reach the largest ROWS-1.
    localparam int CUR_COL_W = 8;
    localparam int CUR_ROW_W = 6;
    localparam int LIN_W     = 11;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_VT      = 8'd11;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] TAB_STOP   = 8'd8;
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    localparam logic REG_PROMPT_COLUMN  = 1'b0;
    localparam logic REG_SCROLL_TOP_ROW = 1'b1;

    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_PUT_AT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t  req_type;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [6:0] cell_col;
        logic [4:0] cell_row;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_linear;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } out_item_t;

    // One classified request, handed from the front end to the screen engine.
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [CUR_ROW_W-1:0] cell_row;
        logic [6:0]           cell_col;
        logic [15:0]          cell_data;
        logic                 copy_en;
        logic                 blank_en;
        logic [CUR_ROW_W-1:0] sweep_row;
        logic [7:0]           attr;
        logic [6:0]           cur_col;
        logic [4:0]           cur_row;
        logic [LIN_W-1:0]     cur_linear;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CELL,
        BK_COPY,
        BK_DRAIN,
        BK_BLANK,
        BK_RESULT
    } back_state_t;

    function automatic logic [15:0] blank_cell(input logic [7:0] attr);
        return {attr, CH_SPACE};
    endfunction

endpackage

### sv/tcc_cmd_fifo.sv
module tcc_cmd_fifo
    import tcc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             entry_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/tcc_front.sv
module tcc_front
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    input  logic [6:0] prompt_column,
    input  logic [4:0] scroll_top_row,
    input  logic       init_busy,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam logic [CUR_COL_W-1:0] COLS     = CUR_COL_W'(COLUMNS);
    localparam logic [CUR_COL_W-1:0] LAST_COL = CUR_COL_W'(COLUMNS - 1);
    localparam logic [CUR_ROW_W-1:0] LAST_ROW = CUR_ROW_W'(ROWS - 1);

    logic [CUR_COL_W-1:0] col_reg, col_next;
    logic [CUR_ROW_W-1:0] row_reg, row_next;

    logic [CUR_COL_W-1:0] home_col, floor_col, prompt_inc, col_step;
    logic [CUR_ROW_W-1:0] top_row, top_raw, row_step;
    logic                 is_ctrl, in_range, do_nl;

    assign s_ready = !q_full && !init_busy;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        prompt_inc = {1'b0, prompt_column} + 1'b1;
        home_col   = ({1'b0, prompt_column} < COLS) ? {1'b0, prompt_column} : LAST_COL;
        floor_col  = (prompt_inc > LAST_COL) ? LAST_COL : prompt_inc;
        top_raw    = {1'b0, scroll_top_row};
        priority if (top_raw == '0) begin
            top_row = CUR_ROW_W'(1);
        end else if (top_raw > LAST_ROW) begin
            top_row = LAST_ROW;
        end else begin
            top_row = top_raw;
        end
    end

    always_comb begin
        q_cmd       = '0;
        q_cmd.attr  = s_data.attribute;
        col_step    = col_reg;
        row_step    = row_reg;
        do_nl       = 1'b0;
        is_ctrl     = (s_data.char_code == CH_TAB) || (s_data.char_code == CH_NL) ||
                      (s_data.char_code == CH_BS) || (s_data.char_code == CH_CR) ||
                      (s_data.char_code == CH_VT);
        in_range    = ({1'b0, s_data.cell_col} <= LAST_COL) &&
                      ({1'b0, s_data.cell_row} <= LAST_ROW);

        // Control characters steer the cursor the same way for both put forms.
        if ((s_data.req_type == REQ_PUT || s_data.req_type == REQ_PUT_AT) && is_ctrl) begin
            priority if (s_data.char_code == CH_TAB) begin
                col_step = {col_reg[CUR_COL_W-1:3], 3'b000} + TAB_STOP;
            end else if (s_data.char_code == CH_NL) begin
                do_nl = 1'b1;
            end else if (s_data.char_code == CH_BS) begin
                col_step        = (col_reg > floor_col) ? col_reg - 1'b1 : floor_col;
                q_cmd.wr_en     = 1'b1;
                q_cmd.cell_row  = row_reg;
                q_cmd.cell_col  = col_step[6:0];
                q_cmd.cell_data = blank_cell(s_data.attribute);
            end else if (s_data.char_code == CH_CR) begin
                col_step = '0;
            end else begin
                row_step = (row_reg < LAST_ROW) ? row_reg + 1'b1 : row_reg;
            end
        end else begin
            unique case (s_data.req_type)
                REQ_PUT: begin
                    q_cmd.wr_en     = 1'b1;
                    q_cmd.cell_row  = row_reg;
                    q_cmd.cell_col  = col_reg[6:0];
                    q_cmd.cell_data = {s_data.attribute, s_data.char_code};
                    col_step        = col_reg + 1'b1;
                end
                REQ_PUT_AT: begin
                    q_cmd.wr_en     = in_range;
                    q_cmd.cell_row  = {1'b0, s_data.cell_row};
                    q_cmd.cell_col  = s_data.cell_col;
                    q_cmd.cell_data = {s_data.attribute, s_data.char_code};
                end
                REQ_CLEAR: begin
                    q_cmd.blank_en  = 1'b1;
                    q_cmd.sweep_row = top_row - 1'b1;
                    col_step        = home_col;
                    row_step        = top_row;
                end
                REQ_READ: begin
                    q_cmd.rd_en    = in_range;
                    q_cmd.cell_row = {1'b0, s_data.cell_row};
                    q_cmd.cell_col = s_data.cell_col;
                end
            endcase
        end

        col_next = col_step;
        row_next = row_step;
        if (do_nl || col_step >= COLS) begin
            col_next = home_col;
            if (row_step < LAST_ROW) begin
                row_next = row_step + 1'b1;
            end else begin
                // A newline or a column wrap on the bottom row scrolls the lower region up.
                q_cmd.copy_en   = 1'b1;
                q_cmd.blank_en  = 1'b1;
                q_cmd.sweep_row = top_row;
            end
        end

        q_cmd.cur_col    = col_next[6:0];
        q_cmd.cur_row    = row_next[4:0];
        q_cmd.cur_linear = LIN_W'(col_next + row_next * COLUMNS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### sv/tcc_back.sv
module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    output logic      q_pop,
    input  cmd_t      q_cmd,
    output logic      init_busy,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(TOTAL - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLUMNS);

    logic [15:0] mem [TOTAL];

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] prev_addr_reg, prev_addr_next;
    logic              pend_reg, pend_next;
    logic [15:0]       rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              mem_we, mem_re, out_load;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr, cell_addr, sweep_base;
    logic [15:0]       mem_wdata;

    assign cell_addr  = ADDR_W'(cmd_reg.cell_row * COLUMNS + cmd_reg.cell_col);
    assign sweep_base = ADDR_W'(cmd_reg.sweep_row * COLUMNS);
    assign init_busy  = (state_reg == BK_INIT);
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        prev_addr_next = prev_addr_reg;
        pend_next      = pend_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = blank_cell(cmd_reg.attr);
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;
        out_load       = 1'b0;

        unique case (state_reg)
            BK_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = blank_cell(RESET_ATTR);
                if (addr_reg == LAST_ADDR) begin
                    state_next = BK_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = BK_CELL;
                end
            end
            BK_CELL: begin
                mem_we    = cmd_reg.wr_en;
                mem_waddr = cell_addr;
                mem_wdata = cmd_reg.cell_data;
                mem_re    = cmd_reg.rd_en;
                mem_raddr = cell_addr;
                addr_next = sweep_base;
                pend_next = 1'b0;
                priority if (cmd_reg.copy_en) begin
                    state_next = BK_COPY;
                end else if (cmd_reg.blank_en) begin
                    state_next = BK_BLANK;
                end else begin
                    state_next = BK_RESULT;
                end
            end
            BK_COPY: begin
                // Read the next cell while the cell read before it is written to the row above.
                mem_re         = 1'b1;
                pend_next      = 1'b1;
                prev_addr_next = addr_reg;
                mem_we         = pend_reg;
                mem_waddr      = prev_addr_reg - ROW_STEP;
                mem_wdata      = rd_data_reg;
                if (addr_reg == LAST_ADDR) begin
                    state_next = BK_DRAIN;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            BK_DRAIN: begin
                mem_we     = 1'b1;
                mem_waddr  = prev_addr_reg - ROW_STEP;
                mem_wdata  = rd_data_reg;
                addr_next  = LAST_ROW_BASE;
                state_next = BK_BLANK;
            end
            BK_BLANK: begin
                mem_we = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    state_next = BK_RESULT;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            BK_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    if (!q_empty) begin
                        q_pop      = 1'b1;
                        cmd_next   = q_cmd;
                        state_next = BK_CELL;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        out_data_next               = out_data_reg;
        if (out_load) begin
            out_data_next.cursor_col    = cmd_reg.cur_col;
            out_data_next.cursor_row    = cmd_reg.cur_row;
            out_data_next.cursor_linear = cmd_reg.cur_linear;
            out_data_next.read_char     = cmd_reg.rd_en ? rd_data_reg[7:0] : 8'd0;
            out_data_next.read_attr     = cmd_reg.rd_en ? rd_data_reg[15:8] : 8'd0;
        end
        out_valid_next = out_load || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_INIT;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        prev_addr_reg <= prev_addr_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

### sv/text_console_char_engine.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  in_item_t   (request)
// m_        out        m_valid / m_ready  out_item_t  (cursor and read data)
// apb       in         psel / penable     prompt_column, scroll_top_row
//
// An ordinary transaction occupies the screen engine for one memory access
// and then the load of the result register. A scroll moves the rows from
// top upward by one row and blanks the last row; a clear blanks the rows
// from top-1 to the last. Both go cell by cell through the single write
// port of the screen memory. After reset the memory is blanked cell by
// cell; s_ready stays low until that pass ends. A two-entry queue lets
// s_ready stay high while the engine works or the result waits on m_ready.
module text_console_char_engine
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] prompt_column_reg;
    logic [4:0] scroll_top_row_reg;
    logic       cfg_write;
    logic       init_busy, q_full, q_empty, q_push, q_pop;
    cmd_t       push_cmd, pop_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_SCROLL_TOP_ROW) ? {27'd0, scroll_top_row_reg}
                                                        : {25'd0, prompt_column_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prompt_column_reg  <= 7'd0;
            scroll_top_row_reg <= 5'd1;
        end else if (cfg_write) begin
            if (paddr[2] == REG_PROMPT_COLUMN) begin
                prompt_column_reg <= pwdata[6:0];
            end else begin
                scroll_top_row_reg <= pwdata[4:0];
            end
        end
    end

    tcc_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .prompt_column (prompt_column_reg),
        .scroll_top_row(scroll_top_row_reg),
        .init_busy     (init_busy),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    tcc_cmd_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .pop     (q_pop),
        .pop_cmd (pop_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    tcc_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_cmd    (pop_cmd),
        .init_busy(init_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### sv/tcc_checker.sv
module tcc_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // The cursor never rests at or past the column count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (ROWS <= 32) |->
            (m_data.cursor_linear == LIN_W'(m_data.cursor_col + m_data.cursor_row * COLUMNS)))
        else $error("linear cursor does not match column and row");

endmodule

bind text_console_char_engine tcc_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
